[rtl/core/euler_angles_to_quaternion_macros.svh]
// Assertion macros shared by the Euler-to-quaternion RTL.
`ifndef EULER_ANGLES_TO_QUATERNION_MACROS_SVH
`define EULER_ANGLES_TO_QUATERNION_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define EAQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EAQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EAQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define EAQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/eaq_pkg.sv]
// Types, constants and helper functions of the Euler-to-quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none

package eaq_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int OUT_FRAC_BITS   = 15;

  localparam int FIELD_W = 16;
  localparam int TBL_N   = 1 << SINE_TABLE_BITS;
  localparam int IDX_W   = SINE_TABLE_BITS + 1;
  localparam int TBL_W   = OUT_FRAC_BITS + 1;
  localparam int SC_W    = OUT_FRAC_BITS + 2;
  localparam int PROD_W  = 2 * OUT_FRAC_BITS + 2;
  localparam int ACC_W   = PROD_W + 1;
  localparam int OUT_W   = OUT_FRAC_BITS + 1;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;
    logic signed [OUT_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [SC_W-1:0] sin_v;
    logic signed [SC_W-1:0] cos_v;
  } sincos_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] cpcy;
    logic signed [PROD_W-1:0] spsy;
    logic signed [PROD_W-1:0] spcy;
    logic signed [PROD_W-1:0] cpsy;
  } pair_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] x_a;
    logic signed [PROD_W-1:0] x_b;
    logic signed [PROD_W-1:0] y_a;
    logic signed [PROD_W-1:0] y_b;
    logic signed [PROD_W-1:0] z_a;
    logic signed [PROD_W-1:0] z_b;
    logic signed [PROD_W-1:0] w_a;
    logic signed [PROD_W-1:0] w_b;
  } mix_t;

  // Q4.60 product, elaboration use only.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Quarter-wave sine entry i, Taylor series in Q60 then rounded to Q1.OUT_FRAC_BITS.
  function automatic logic [TBL_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] fmask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    fmask = (64'd1 << SINE_TABLE_BITS) - 64'd1;
    x = (HALF_PI_Q60 >> SINE_TABLE_BITS) * 64'(i) +
        (((HALF_PI_Q60 & fmask) * 64'(i)) >> SINE_TABLE_BITS);
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int k = 1; k <= 14; k++) begin
      term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (sum + (64'd1 << (59 - OUT_FRAC_BITS))) >> (60 - OUT_FRAC_BITS);
    return rnd[TBL_W-1:0];
  endfunction

  // Drop OUT_FRAC_BITS fraction bits, round to nearest, half away from zero.
  function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] bias;
    bias = $signed(ACC_W'(1) << (OUT_FRAC_BITS - 1)) - $signed(ACC_W'(v[ACC_W-1]));
    return (v + bias) >>> OUT_FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

[rtl/core/eaq_half_sincos.sv]
// Half-angle sine and cosine lookup from a quarter-wave ROM, registered read.
`timescale 1ns / 1ps
`default_nettype none

module eaq_half_sincos (
  input  wire                                       clk,
  input  wire                                       en,
  input  wire logic signed [eaq_pkg::FIELD_W-1:0]   ang,
  output eaq_pkg::sincos_t                          sc
);

  localparam int AB    = eaq_pkg::ANGLE_BITS;
  localparam int SH    = AB - 1 - eaq_pkg::SINE_TABLE_BITS;
  localparam int IDX_W = eaq_pkg::IDX_W;
  localparam int TBL_W = eaq_pkg::TBL_W;
  localparam int TBL_N = eaq_pkg::TBL_N;

  logic [AB-1:0]    a;
  logic [AB-1:0]    mag;
  logic             neg;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] cidx;
  logic [TBL_W-1:0] rom [0:TBL_N];
  logic [TBL_W-1:0] s_mag;
  logic [TBL_W-1:0] c_mag;
  logic             neg_q;

  assign a   = ang[AB-1:0];
  assign neg = a[AB-1];
  assign mag = neg ? (~a + AB'(1)) : a;

  if (SH > 0) begin : g_round
    localparam logic [AB:0] BIAS = (AB + 1)'(1) << (SH - 1);
    logic [AB:0] biased;
    logic [AB:0] shifted;
    assign biased  = {1'b0, mag} + BIAS;
    assign shifted = biased >> SH;
    assign idx = (shifted > (AB + 1)'(TBL_N)) ? IDX_W'(TBL_N) : shifted[IDX_W-1:0];
  end else begin : g_widen
    logic [IDX_W-1:0] wide;
    assign wide = IDX_W'(mag) << (-SH);
    assign idx  = (wide > IDX_W'(TBL_N)) ? IDX_W'(TBL_N) : wide;
  end

  assign cidx = IDX_W'(TBL_N) - idx;

  for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
    localparam logic [TBL_W-1:0] ENTRY = eaq_pkg::sine_entry(g);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_mag <= rom[idx];
      c_mag <= rom[cidx];
      neg_q <= neg;
    end
  end

  assign sc.sin_v = neg_q ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign sc.cos_v = $signed({1'b0, c_mag});

endmodule

`default_nettype wire

[rtl/core/eaq_pair_prod.sv]
// Pitch/yaw pair products, registered; roll sine and cosine travel alongside.
`timescale 1ns / 1ps
`default_nettype none

module eaq_pair_prod (
  input  wire                     clk,
  input  wire                     en,
  input  wire eaq_pkg::sincos_t   pitch,
  input  wire eaq_pkg::sincos_t   yaw,
  input  wire eaq_pkg::sincos_t   roll,
  output eaq_pkg::pair_t          pr,
  output eaq_pkg::sincos_t        roll_q
);

  localparam int FULL_W = 2 * eaq_pkg::SC_W;
  localparam int PROD_W = eaq_pkg::PROD_W;

  logic signed [FULL_W-1:0] cpcy;
  logic signed [FULL_W-1:0] spsy;
  logic signed [FULL_W-1:0] spcy;
  logic signed [FULL_W-1:0] cpsy;

  assign cpcy = pitch.cos_v * yaw.cos_v;
  assign spsy = pitch.sin_v * yaw.sin_v;
  assign spcy = pitch.sin_v * yaw.cos_v;
  assign cpsy = pitch.cos_v * yaw.sin_v;

  // Magnitudes stay within 2^(2F), so the top bits are pure sign.
  always_ff @(posedge clk) begin
    if (en) begin
      pr.cpcy <= PROD_W'(cpcy);
      pr.spsy <= PROD_W'(spsy);
      pr.spcy <= PROD_W'(spcy);
      pr.cpsy <= PROD_W'(cpsy);
      roll_q  <= roll;
    end
  end

endmodule

`default_nettype wire

[rtl/core/eaq_roll_mix.sv]
// Round the pair products and multiply them by the roll sine and cosine.
`timescale 1ns / 1ps
`default_nettype none

module eaq_roll_mix (
  input  wire                     clk,
  input  wire                     en,
  input  wire eaq_pkg::pair_t     pr,
  input  wire eaq_pkg::sincos_t   roll,
  output eaq_pkg::mix_t           mix
);

  localparam int SC_W   = eaq_pkg::SC_W;
  localparam int ACC_W  = eaq_pkg::ACC_W;
  localparam int PROD_W = eaq_pkg::PROD_W;

  logic signed [SC_W-1:0] cpcy_r;
  logic signed [SC_W-1:0] spsy_r;
  logic signed [SC_W-1:0] spcy_r;
  logic signed [SC_W-1:0] cpsy_r;

  assign cpcy_r = SC_W'(eaq_pkg::round_frac(ACC_W'(pr.cpcy)));
  assign spsy_r = SC_W'(eaq_pkg::round_frac(ACC_W'(pr.spsy)));
  assign spcy_r = SC_W'(eaq_pkg::round_frac(ACC_W'(pr.spcy)));
  assign cpsy_r = SC_W'(eaq_pkg::round_frac(ACC_W'(pr.cpsy)));

  always_ff @(posedge clk) begin
    if (en) begin
      mix.x_a <= PROD_W'(roll.sin_v * cpcy_r);
      mix.x_b <= PROD_W'(roll.cos_v * spsy_r);
      mix.y_a <= PROD_W'(roll.cos_v * spcy_r);
      mix.y_b <= PROD_W'(roll.sin_v * cpsy_r);
      mix.z_a <= PROD_W'(roll.cos_v * cpsy_r);
      mix.z_b <= PROD_W'(roll.sin_v * spcy_r);
      mix.w_a <= PROD_W'(roll.cos_v * cpcy_r);
      mix.w_b <= PROD_W'(roll.sin_v * spsy_r);
    end
  end

endmodule

`default_nettype wire

[rtl/core/eaq_quat_out.sv]
// Final sums, rounding and saturation into the output register.
`timescale 1ns / 1ps
`default_nettype none

module eaq_quat_out (
  input  wire                   clk,
  input  wire                   en,
  input  wire eaq_pkg::mix_t    mix,
  output eaq_pkg::quat_t        quat
);

  localparam int ACC_W = eaq_pkg::ACC_W;
  localparam int OUT_W = eaq_pkg::OUT_W;
  localparam int F     = eaq_pkg::OUT_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] SAT_HI = $signed((ACC_W'(1) << F) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] SAT_LO = $signed(-(ACC_W'(1) << F));

  logic signed [ACC_W-1:0] sx;
  logic signed [ACC_W-1:0] sy;
  logic signed [ACC_W-1:0] sz;
  logic signed [ACC_W-1:0] sw;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = eaq_pkg::round_frac(v);
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return OUT_W'(r);
  endfunction

  assign sx = ACC_W'(mix.x_a) - ACC_W'(mix.x_b);
  assign sy = ACC_W'(mix.y_a) + ACC_W'(mix.y_b);
  assign sz = ACC_W'(mix.z_a) - ACC_W'(mix.z_b);
  assign sw = ACC_W'(mix.w_a) + ACC_W'(mix.w_b);

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_x <= finish(sx);
      quat.quat_y <= finish(sy);
      quat.quat_z <= finish(sz);
      quat.quat_w <= finish(sw);
    end
  end

endmodule

`default_nettype wire

[rtl/core/euler_angles_to_quaternion.sv]
// Top level: pipelined Z-Y-X Euler angle to unit quaternion converter.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (angle_valid / angle_stall / angle): one beat carries pitch,
//   yaw and roll as 16-bit binary angles, 65536 units to a full turn.
//   Output channel (quat_valid / quat_stall / quat): one beat carries the
//   quaternion x, y, z, w in Q1.15; +1.0 saturates to 32767.
//   A beat moves on a rising edge with valid high and stall low.
// Path: an accepted input beat passes through four register stages
//   (half-angle ROM read, pitch/yaw products, roll products, sums with
//   rounding into the output register) on its way to its output beat.
// Throughput: one beat per cycle while the output is not stalled; each
//   angle has its own dual-read sine ROM, so no unit is shared between beats.
// Reset (rst, synchronous): empties every stage; no output beat is shown
//   until a new input beat has gone through. No table fill is needed.
// Stall: a stalled output holds its beat. Upstream stages keep advancing
//   into any empty stage behind it, so angle_stall rises only once all four
//   stages hold a beat and the output is still stalled.

`include "euler_angles_to_quaternion_macros.svh"

module euler_angles_to_quaternion (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    angle_valid,
  output logic                   angle_stall,
  input  wire eaq_pkg::angles_t  angle,
  output logic                   quat_valid,
  input  wire                    quat_stall,
  output eaq_pkg::quat_t         quat
);

  // Stage occupancy; quat_valid is the occupancy of the output register.
  logic stage1_valid;
  logic stage2_valid;
  logic stage3_valid;

  // A stage advances when it is empty or the stage after it advances.
  logic adv1;
  logic adv2;
  logic adv3;
  logic adv4;

  // Every stage holds a beat and the output is stalled.
  logic full_held;
  // Nothing in stage 3 and no output beat held back.
  logic out_idle;

  eaq_pkg::sincos_t pitch_sc;
  eaq_pkg::sincos_t yaw_sc;
  eaq_pkg::sincos_t roll_sc;
  eaq_pkg::sincos_t roll_sc_q;
  eaq_pkg::pair_t   pair;
  eaq_pkg::mix_t    mix;

  assign adv4 = !quat_valid || !quat_stall;
  assign adv3 = !stage3_valid || adv4;
  assign adv2 = !stage2_valid || adv3;
  assign adv1 = !stage1_valid || adv2;

  // Hold the input side off only while stage one cannot take a beat.
  assign angle_stall = !adv1;

  // Advance the valid bits alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
      quat_valid   <= 1'b0;
    end else begin
      if (adv1) begin
        stage1_valid <= angle_valid;
      end
      if (adv2) begin
        stage2_valid <= stage1_valid;
      end
      if (adv3) begin
        stage3_valid <= stage2_valid;
      end
      if (adv4) begin
        quat_valid <= stage3_valid;
      end
    end
  end

  // Stage 1: half-angle sine and cosine of each angle.
  eaq_half_sincos u_pitch_sc (
    .clk (clk),
    .en  (adv1),
    .ang (angle.pitch_angle),
    .sc  (pitch_sc)
  );

  eaq_half_sincos u_yaw_sc (
    .clk (clk),
    .en  (adv1),
    .ang (angle.yaw_angle),
    .sc  (yaw_sc)
  );

  eaq_half_sincos u_roll_sc (
    .clk (clk),
    .en  (adv1),
    .ang (angle.roll_angle),
    .sc  (roll_sc)
  );

  // Stage 2: pitch/yaw pair products.
  eaq_pair_prod u_pair_prod (
    .clk    (clk),
    .en     (adv2),
    .pitch  (pitch_sc),
    .yaw    (yaw_sc),
    .roll   (roll_sc),
    .pr     (pair),
    .roll_q (roll_sc_q)
  );

  // Stage 3: round pair products, weight by roll sine and cosine.
  eaq_roll_mix u_roll_mix (
    .clk  (clk),
    .en   (adv3),
    .pr   (pair),
    .roll (roll_sc_q),
    .mix  (mix)
  );

  // Stage 4: sum, round, saturate into the output register.
  eaq_quat_out u_quat_out (
    .clk  (clk),
    .en   (adv4),
    .mix  (mix),
    .quat (quat)
  );

  assign full_held = stage1_valid && stage2_valid && stage3_valid && quat_valid && quat_stall;
  assign out_idle  = !stage3_valid && !(quat_valid && quat_stall);

  // Input stall must only come from a full pipeline behind a stalled output.
  `EAQ_ASSERT_IMPL(a_in_stall, clk, rst, angle_stall, full_held, "input stalled with a free stage")
  // A beat leaving stage 3 must land in the output register.
  `EAQ_ASSERT_NEXT(a_beat_out, clk, rst, stage3_valid && adv4, quat_valid, "stage 3 beat lost")
  // No output beat appears without a beat in stage 3 or a held output.
  `EAQ_ASSERT_NEXT(a_no_phantom, clk, rst, out_idle, !quat_valid, "output beat without a source")

endmodule

`default_nettype wire
